/* rtl/core/ebp_pkg.sv */
// shared types and constants for the extent block partitioner
package ebp_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_BLOCKS = 64;
	localparam int CFG_BITS   = 16;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SPLIT_ENABLE = 2'd0;
	localparam logic [1:0] REG_MIN_SIZE_X   = 2'd1;
	localparam logic [1:0] REG_MIN_SIZE_Y   = 2'd2;
	localparam logic [1:0] REG_MIN_SIZE_Z   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INFEASIBLE = 2'd1;
	localparam logic [1:0] ST_NO_SPLIT   = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	typedef struct packed {
		logic [COORD_BITS-1:0] x_low;
		logic [COORD_BITS-1:0] x_high;
		logic [COORD_BITS-1:0] y_low;
		logic [COORD_BITS-1:0] y_high;
		logic [COORD_BITS-1:0] z_low;
		logic [COORD_BITS-1:0] z_high;
		logic [15:0]           block_count;
	} req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] blk_x_low;
		logic [COORD_BITS-1:0] blk_x_high;
		logic [COORD_BITS-1:0] blk_y_low;
		logic [COORD_BITS-1:0] blk_y_high;
		logic [COORD_BITS-1:0] blk_z_low;
		logic [COORD_BITS-1:0] blk_z_high;
		logic                  last_block;
		logic [1:0]            status;
	} blk_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] hi;
		logic [COORD_BITS-1:0] lo;
	} rng_t;

	// index 0 is x, 1 is y, 2 is z
	typedef rng_t [2:0] ent_t;

endpackage

/* rtl/core/extent_block_partitioner_core.sv */
// extent block partitioner: splits one 3d extent into a requested number of blocks
//
// A request transaction (req_valid/req_stall) carries an inclusive x/y/z extent
// and a block count. The block answers with one result transaction per block on
// blk_valid/blk_stall, the final one flagged last_block; an error gives a single
// flagged result with zero bounds and a nonzero status.
// Requests are handled one at a time: req_stall stays high from acceptance until
// the last result has been loaded into the output register.
// Sequence: a range check, the per-axis block count (repeated addition of the
// minimum size), the product of the counts, then for each queue entry visited
// while splitting one read and up to two writes to the block queue memory,
// then a queue read and an output load per emitted block.
// The queue memory holds 64 entries of three ranges and needs no clearing pass.
// Reset returns the sequencer to idle, empties the output register and sets
// split_enable to 7 and all minimum sizes to 1.
// When the receiver stalls, the result stays in the output register and the
// sequencer waits before reading the next block out of the queue.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module extent_block_partitioner_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ebp_pkg::req_t        req,
	output logic                 blk_valid,
	input  logic                 blk_stall,
	output ebp_pkg::blk_t        blk,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [ebp_pkg::CFG_BITS-1:0] cfg_data
);
	import ebp_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int FW = AW + 1;
	localparam int LW = COORD_BITS + 1;
	localparam int AC = COORD_BITS + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_DIV, S_MUL1, S_MUL2, S_FEAS, S_PASS, S_AXIS,
		S_RD, S_SPLIT, S_PUSH, S_ERD, S_ELD, S_ERR
	} state_t;

	state_t state_q;

	logic [2:0]            split_en_q;
	logic [COORD_BITS-1:0] min_q [3];

	ent_t                  ext_q;
	logic [15:0]           n_q;
	logic [FW-1:0]         n7;
	logic [1:0]            err_q;
	logic [2:0][FW-1:0]    f_q;
	logic [2:0][AC-1:0]    acc_q;
	logic [FW-1:0]         nb_q;
	logic [2:0][1:0]       order_q;
	logic [1:0]            nd_q;
	logic [1:0]            d_q;
	logic                  any_q;
	logic [FW-1:0]         cnt_q;
	logic [FW-1:0]         i_q;
	logic [AW-1:0]         head_q;
	logic [FW-1:0]         fill_q;
	ent_t                  first_q;
	blk_t                  out_q;
	logic                  out_valid_q;

	// queue memory
	ent_t                  mem [MAX_BLOCKS];
	ent_t                  rdata_s1;
	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         waddr;
	ent_t                  wdata;

	// combinational helpers
	logic [2:0][COORD_BITS-1:0] mn;
	logic [2:0][LW-1:0]         len;
	logic [2:0]                 en;
	logic [2:0]                 splittable;
	logic [2:0][1:0]            order_c;
	logic [1:0]                 nd_c;
	logic                       range_bad;
	logic [2:0]                 div_step;
	logic [2*FW-1:0]            prod;
	logic [FW-1:0]              prod_cap;
	logic                       out_free;
	logic [1:0]                 ax;
	logic [LW-1:0]              ni;
	logic                       do_split;
	logic [COORD_BITS-1:0]      mid;
	logic [LW-1:0]              mid_p1;
	logic [COORD_BITS-1:0]      slo;
	ent_t                       sec_c;
	ent_t                       fst_c;
	logic [FW-1:0]              fill_dec;

	assign n7 = n_q[FW-1:0];
	assign out_free = !out_valid_q || !blk_stall;

	always_comb begin
		range_bad = 1'b0;
		nd_c = '0;
		order_c = '0;
		for (int a = 0; a < 3; a++) begin
			mn[a] = (min_q[a] == '0) ? COORD_BITS'(1) : min_q[a];
			len[a] = LW'(ext_q[a].hi) - LW'(ext_q[a].lo) + LW'(1);
			en[a] = split_en_q[a];
			splittable[a] = en[a] && (len[a] > LW'(mn[a]));
			if (ext_q[a].hi < ext_q[a].lo)
				range_bad = 1'b1;
			div_step[a] = en[a] && (acc_q[a] < AC'(len[a])) && (f_q[a] < FW'(MAX_BLOCKS));
		end
		// z first, then y, then x
		for (int a = 2; a >= 0; a--) begin
			if (splittable[a]) begin
				order_c[nd_c] = 2'(a);
				nd_c = nd_c + 2'd1;
			end
		end
	end

	always_comb begin
		if (state_q == S_MUL1)
			prod = f_q[0] * f_q[1];
		else
			prod = nb_q * f_q[2];
		prod_cap = (prod > (2*FW)'(MAX_BLOCKS)) ? FW'(MAX_BLOCKS) : prod[FW-1:0];
	end

	// split of the block just read from the queue
	always_comb begin
		ax = order_q[d_q];
		if (ax > 2'd2)
			ax = 2'd2;
		ni = LW'(rdata_s1[ax].hi) - LW'(rdata_s1[ax].lo) + LW'(1);
		do_split = ni >= {mn[ax], 1'b0};
		mid = rdata_s1[ax].lo + ni[LW-1:1];
		mid_p1 = LW'(mid) + LW'(1);
		slo = (mid_p1 < LW'(rdata_s1[ax].hi)) ? mid_p1[COORD_BITS-1:0] : rdata_s1[ax].hi;
		sec_c = rdata_s1;
		sec_c[ax].lo = slo;
		fst_c = rdata_s1;
		fst_c[ax].hi = mid;
	end

	assign fill_dec = fill_q - FW'(1);

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr = head_q + fill_q[AW-1:0];
		wdata = first_q;
		case (state_q)
			S_FEAS: begin
				mem_we = (nb_q >= FW'(n_q)) || (n_q > 16'(MAX_BLOCKS));
				waddr = '0;
				wdata = ext_q;
			end
			S_SPLIT: begin
				mem_we = do_split;
				wdata = sec_c;
			end
			S_PUSH: begin
				mem_we = 1'b1;
			end
			S_RD: mem_re = 1'b1;
			S_ERD: mem_re = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_s1 <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_en_q <= 3'd7;
			min_q[0] <= COORD_BITS'(1);
			min_q[1] <= COORD_BITS'(1);
			min_q[2] <= COORD_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPLIT_ENABLE: split_en_q <= cfg_data[2:0];
				REG_MIN_SIZE_X:   min_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_MIN_SIZE_Y:   min_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_MIN_SIZE_Z:   min_q[2] <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			head_q <= '0;
			fill_q <= '0;
			order_q <= '0;
			nd_q <= '0;
			d_q <= '0;
			any_q <= 1'b0;
			cnt_q <= '0;
			i_q <= '0;
			err_q <= ST_OK;
			nb_q <= '0;
			f_q <= '0;
			acc_q <= '0;
		end else begin
			// the load states set valid themselves
			if (out_valid_q && !blk_stall && state_q != S_ERR && state_q != S_ELD)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						ext_q[0] <= '{hi: req.x_high, lo: req.x_low};
						ext_q[1] <= '{hi: req.y_high, lo: req.y_low};
						ext_q[2] <= '{hi: req.z_high, lo: req.z_low};
						n_q <= req.block_count;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (range_bad || n_q > 16'(MAX_BLOCKS)) begin
						err_q <= ST_RANGE;
						state_q <= S_ERR;
					end else begin
						for (int a = 0; a < 3; a++) begin
							acc_q[a] <= '0;
							f_q[a] <= en[a] ? FW'(0) : FW'(1);
						end
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// ceiling block count per axis by repeated addition, capped
					for (int a = 0; a < 3; a++) begin
						if (div_step[a]) begin
							acc_q[a] <= acc_q[a] + AC'(mn[a]);
							f_q[a] <= f_q[a] + FW'(1);
						end
					end
					if (div_step == '0)
						state_q <= S_MUL1;
				end
				S_MUL1: begin
					nb_q <= prod_cap;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					nb_q <= prod_cap;
					state_q <= S_FEAS;
				end
				S_FEAS: begin
					if (nb_q < n7) begin
						err_q <= ST_INFEASIBLE;
						state_q <= S_ERR;
					end else begin
						order_q <= order_c;
						nd_q <= nd_c;
						head_q <= '0;
						fill_q <= FW'(1);
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (fill_q >= n7) begin
						state_q <= S_ERD;
					end else begin
						d_q <= '0;
						any_q <= 1'b0;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					if (d_q == nd_q) begin
						if (!any_q) begin
							err_q <= ST_NO_SPLIT;
							state_q <= S_ERR;
						end else begin
							state_q <= S_PASS;
						end
					end else begin
						cnt_q <= fill_q;
						i_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					head_q <= head_q + AW'(1);
					fill_q <= fill_dec;
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					// second half goes in ahead of the first
					first_q <= do_split ? fst_c : rdata_s1;
					if (do_split) begin
						fill_q <= fill_q + FW'(1);
						any_q <= 1'b1;
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					fill_q <= fill_q + FW'(1);
					if (fill_q + FW'(1) == n7) begin
						state_q <= S_ERD;
					end else if (i_q + FW'(1) == cnt_q) begin
						d_q <= d_q + 2'd1;
						state_q <= S_AXIS;
					end else begin
						i_q <= i_q + FW'(1);
						state_q <= S_RD;
					end
				end
				S_ERD: begin
					if (out_free) begin
						head_q <= head_q + AW'(1);
						fill_q <= fill_dec;
						state_q <= S_ELD;
					end
				end
				S_ELD: begin
					out_q.blk_x_low  <= rdata_s1[0].lo;
					out_q.blk_x_high <= rdata_s1[0].hi;
					out_q.blk_y_low  <= rdata_s1[1].lo;
					out_q.blk_y_high <= rdata_s1[1].hi;
					out_q.blk_z_low  <= rdata_s1[2].lo;
					out_q.blk_z_high <= rdata_s1[2].hi;
					out_q.last_block <= (fill_q == '0);
					out_q.status <= ST_OK;
					out_valid_q <= 1'b1;
					state_q <= (fill_q == '0) ? S_IDLE : S_ERD;
				end
				S_ERR: begin
					if (out_free) begin
						out_q <= '{blk_x_low: '0, blk_x_high: '0, blk_y_low: '0,
							blk_y_high: '0, blk_z_low: '0, blk_z_high: '0,
							last_block: 1'b1, status: err_q};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign blk_valid = out_valid_q;
	assign blk = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_BLOCKS))
		else $error("queue fill above capacity");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && blk.status != ST_OK |-> blk.last_block)
		else $error("error result not flagged last");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ERD |-> fill_q != '0)
		else $error("emit read from empty queue");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ELD |-> $past(state_q) == S_ERD)
		else $error("result load without queue read");

endmodule

/* dv/testbench.sv */
// self-checking testbench for the extent block partitioner core
module testbench;
	import ebp_pkg::*;

	localparam int EXP_DEPTH = 256;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic blk_valid;
	logic blk_stall;
	blk_t blk;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	extent_block_partitioner_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.blk_valid(blk_valid), .blk_stall(blk_stall), .blk(blk),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the registers
	logic [2:0] split_en;
	int min_sz[3];

	// expected results, ring of predicted block transactions
	blk_t exp_mem[EXP_DEPTH];
	int exp_wr;
	int exp_rd;
	int mismatches;
	int requests_sent;
	int blocks_seen;
	int hold_cycles;
	bit quiet;

	always #1 clk = ~clk;

	initial begin
		clk = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		blk_stall = 0;
		cfg_we = 0;
		cfg_index = REG_SPLIT_ENABLE;
		cfg_data = '0;
		split_en = 3'd7;
		min_sz = '{1, 1, 1};
		exp_wr = 0;
		exp_rd = 0;
		mismatches = 0;
		requests_sent = 0;
		blocks_seen = 0;
		hold_cycles = 0;
		quiet = 0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void queue_expected(blk_t b);
		exp_mem[exp_wr % EXP_DEPTH] = b;
		exp_wr++;
	endfunction

	function automatic blk_t error_block(logic [1:0] code);
		blk_t b;
		b = '0;
		b.last_block = 1'b1;
		b.status = code;
		return b;
	endfunction

	// computes the blocks one request produces under the current registers
	function automatic void partition_extent(req_t r);
		int lo[3], hi[3], len[3], mn[3];
		bit en[3];
		int n, nb, f, nd, ax, cnt, ni, mid, head, fill, idx;
		int order[3];
		int qlo[MAX_BLOCKS][3], qhi[MAX_BLOCKS][3];
		int blo[3], bhi[3], slo[3], shi[3];
		bit any, finished;
		blk_t b;
		lo = '{r.x_low, r.y_low, r.z_low};
		hi = '{r.x_high, r.y_high, r.z_high};
		n = r.block_count;
		for (int a = 0; a < 3; a++)
			mn[a] = (min_sz[a] == 0) ? 1 : min_sz[a];
		for (int a = 0; a < 3; a++)
			if (hi[a] < lo[a]) begin
				queue_expected(error_block(ST_RANGE));
				return;
			end
		if (n > MAX_BLOCKS) begin
			queue_expected(error_block(ST_RANGE));
			return;
		end
		nb = 1;
		for (int a = 0; a < 3; a++) begin
			len[a] = hi[a] - lo[a] + 1;
			en[a] = split_en[a];
			f = 1;
			if (en[a]) begin
				f = (len[a] + mn[a] - 1) / mn[a];
				if (f > MAX_BLOCKS) f = MAX_BLOCKS;
			end
			nb = nb * f;
			if (nb > MAX_BLOCKS) nb = MAX_BLOCKS;
		end
		if (nb < n) begin
			queue_expected(error_block(ST_INFEASIBLE));
			return;
		end
		nd = 0;
		for (int a = 2; a >= 0; a--)
			if (en[a] && len[a] > mn[a]) begin
				order[nd] = a;
				nd++;
			end
		head = 0;
		fill = 1;
		qlo[0] = lo;
		qhi[0] = hi;
		finished = 0;
		while (!finished && fill < n) begin
			any = 0;
			for (int d = 0; d < nd && !finished; d++) begin
				ax = order[d];
				cnt = fill;
				for (int i = 0; i < cnt && !finished; i++) begin
					blo = qlo[head];
					bhi = qhi[head];
					head = (head + 1) % MAX_BLOCKS;
					fill--;
					ni = bhi[ax] - blo[ax] + 1;
					if (ni >= 2 * mn[ax]) begin
						mid = blo[ax] + ni / 2;
						slo = blo;
						shi = bhi;
						slo[ax] = (mid + 1 < bhi[ax]) ? mid + 1 : bhi[ax];
						bhi[ax] = mid;
						idx = (head + fill) % MAX_BLOCKS;
						qlo[idx] = slo;
						qhi[idx] = shi;
						fill++;
						any = 1;
					end
					idx = (head + fill) % MAX_BLOCKS;
					qlo[idx] = blo;
					qhi[idx] = bhi;
					fill++;
					if (fill == n) finished = 1;
				end
			end
			if (!finished && !any) begin
				queue_expected(error_block(ST_NO_SPLIT));
				return;
			end
		end
		for (int k = 0; k < fill; k++) begin
			idx = (head + k) % MAX_BLOCKS;
			b.blk_x_low = COORD_BITS'(qlo[idx][0]);
			b.blk_x_high = COORD_BITS'(qhi[idx][0]);
			b.blk_y_low = COORD_BITS'(qlo[idx][1]);
			b.blk_y_high = COORD_BITS'(qhi[idx][1]);
			b.blk_z_low = COORD_BITS'(qlo[idx][2]);
			b.blk_z_high = COORD_BITS'(qhi[idx][2]);
			b.last_block = (k + 1 == fill);
			b.status = ST_OK;
			queue_expected(b);
		end
	endfunction

	// valid is left high after acceptance only when the next transaction follows at once
	task automatic send_req(req_t r);
		int gap;
		gap = quiet ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		partition_extent(r);
		requests_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_regs(logic [2:0] en, int mx, int my, int mz);
		logic [1:0] idx_list[4];
		int val_list[4];
		idx_list = '{REG_SPLIT_ENABLE, REG_MIN_SIZE_X, REG_MIN_SIZE_Y, REG_MIN_SIZE_Z};
		val_list = '{int'(en), mx, my, mz};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= CFG_BITS'(val_list[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		split_en = en;
		min_sz = '{mx, my, mz};
	endtask

	function automatic req_t make_req(int xl, int xh, int yl, int yh, int zl, int zh, int n);
		req_t r;
		r = '{COORD_BITS'(xl), COORD_BITS'(xh), COORD_BITS'(yl), COORD_BITS'(yh),
			COORD_BITS'(zl), COORD_BITS'(zh), 16'(n)};
		return r;
	endfunction

	function automatic req_t rand_req();
		int lo[3], hi[3], len;
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 9) == 0) begin
				lo[a] = $urandom_range(0, 65535);
				hi[a] = $urandom_range(0, 65535);
			end else begin
				lo[a] = $urandom_range(0, 65535);
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
					: $urandom_range(1, 24);
				hi[a] = lo[a] + len - 1;
				if (hi[a] > 65535) hi[a] = 65535;
			end
		end
		return make_req(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
			($urandom_range(0, 9) == 0) ? $urandom_range(65, 65535)
				: $urandom_range(0, 64));
	endfunction

	// result stall: short bursts, a few long ones, forced hold-off when asked
	always @(posedge clk) begin
		int run;
		if (hold_cycles > 0) begin
			blk_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (run > 0) begin
			blk_stall <= 1'b1;
			run--;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			blk_stall <= 1'b1;
			run = pick_gap() - 1;
		end else begin
			blk_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		blk_t want;
		if (arst_n && blk_valid && !blk_stall) begin
			blocks_seen++;
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected block transaction: %p", blk);
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (blk.blk_x_low !== want.blk_x_low || blk.blk_x_high !== want.blk_x_high ||
					blk.blk_y_low !== want.blk_y_low || blk.blk_y_high !== want.blk_y_high ||
					blk.blk_z_low !== want.blk_z_low || blk.blk_z_high !== want.blk_z_high ||
					blk.last_block !== want.last_block || blk.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("block mismatch: expected %p actual %p", want, blk);
				end
			end
		end
	end

	task automatic test_directed();
		send_req(make_req(10, 20, 3, 3, 7, 9, 0));
		send_req(make_req(10, 20, 3, 3, 7, 9, 1));
		send_req(make_req(0, 65535, 0, 65535, 0, 65535, 64));
		send_req(make_req(65535, 65535, 65535, 65535, 65535, 65535, 1));
		// two-index block overlaps its halves at minimum size one
		send_req(make_req(5, 6, 0, 0, 0, 0, 2));
		send_req(make_req(0, 99, 0, 99, 0, 99, 37));
		send_req(make_req(9, 8, 0, 0, 0, 0, 1));
		send_req(make_req(0, 0, 9, 8, 0, 0, 1));
		send_req(make_req(0, 0, 0, 0, 65535, 0, 1));
		send_req(make_req(0, 9, 0, 9, 0, 9, 65));
		send_req(make_req(0, 9, 0, 9, 0, 9, 65535));
		send_req(make_req(4, 4, 4, 4, 4, 4, 2));
		send_req(make_req(0, 3, 0, 1, 0, 0, 8));
		drain();
		write_regs(3'd0, 1, 1, 1);
		send_req(make_req(0, 63, 0, 63, 0, 63, 2));
		send_req(make_req(0, 63, 0, 63, 0, 63, 1));
		drain();
		// feasible by count but no block is long enough to halve
		write_regs(3'd7, 3, 3, 3);
		send_req(make_req(0, 3, 0, 0, 0, 0, 2));
		send_req(make_req(0, 11, 0, 11, 0, 11, 27));
		drain();
		// zero minimum sizes behave as one
		write_regs(3'd5, 0, 0, 0);
		send_req(make_req(0, 15, 0, 15, 0, 15, 16));
		drain();
		write_regs(3'd7, 65535, 65535, 65535);
		send_req(make_req(0, 65535, 0, 65535, 0, 65535, 8));
		send_req(make_req(0, 65535, 0, 65535, 0, 65535, 9));
		drain();
	endtask

	task automatic test_random_configs();
		for (int p = 0; p < 7; p++) begin
			quiet = (p == 3);
			if (p == 0)
				write_regs(3'd7, 1, 1, 1);
			else
				write_regs(3'($urandom_range(0, 7)), $urandom_range(0, 6),
					$urandom_range(0, 6), $urandom_range(0, 6));
			repeat (38) send_req(rand_req());
			drain();
		end
		quiet = 0;
	endtask

	task automatic test_backpressure();
		write_regs(3'd7, 1, 2, 1);
		hold_cycles = 600;
		repeat (12) send_req(make_req(0, 200, 0, 200, 0, 200, $urandom_range(32, 64)));
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_configs();
		test_backpressure();
		$display("sent %0d requests, checked %0d block transactions", requests_sent,
			blocks_seen);
		$display("covered errors, all split enables, min sizes 0..65535, stalls");
		if (mismatches == 0 && exp_wr == exp_rd) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d blocks missing", mismatches,
				exp_wr - exp_rd);
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d blocks outstanding", exp_wr - exp_rd);
		$display("tb: failure");
		$finish;
	end

endmodule
